[rtl/mqrf_pkg.sv]
// ----------------------------------------------------------------------------
// mqrf_pkg
// Shared widths, request and status codes, default sizes and the command
// bundle that the controller sends to the datapath of the multi-queue FIFO.
// ----------------------------------------------------------------------------
package mqrf_pkg;

   localparam int MODE_W  = 2;
   localparam int QIDX_W  = 3;
   localparam int WORD_W  = 32;
   localparam int STAT_W  = 2;
   localparam int FILL_W  = 5;

   localparam int DEF_QUEUE_COUNT = 4;
   localparam int DEF_QUEUE_DEPTH = 16;

   typedef logic [MODE_W-1:0] mode_type;
   typedef logic [STAT_W-1:0] status_type;

   localparam mode_type MODE_CLEAR = 2'd0;
   localparam mode_type MODE_WRITE = 2'd1;
   localparam mode_type MODE_READ  = 2'd2;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_BAD   = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;
   localparam status_type STATUS_EMPTY = 2'd3;

   typedef struct packed {
      logic capture;
      logic execute;
   } mqrf_cmd_type;

endpackage

[rtl/mqrf_chan_if.sv]
// ----------------------------------------------------------------------------
// mqrf channel interfaces
// Valid/ready channels that carry one request into the block and one
// response out of it.
// ----------------------------------------------------------------------------
interface mqrf_req_if import mqrf_pkg::*; ();
   logic                valid;
   logic                ready;
   mode_type            mode;
   logic [QIDX_W-1:0]   queue_index;
   logic [WORD_W-1:0]   write_word;

   modport source (output valid, mode, queue_index, write_word, input ready);
   modport sink (input valid, mode, queue_index, write_word, output ready);
endinterface

interface mqrf_rsp_if import mqrf_pkg::*; ();
   logic                valid;
   logic                ready;
   status_type          status;
   logic [WORD_W-1:0]   read_word;
   logic [FILL_W-1:0]   fill_level;
   logic [WORD_W-1:0]   lost_total;

   modport source (output valid, status, read_word, fill_level, lost_total, input ready);
   modport sink (input valid, status, read_word, fill_level, lost_total, output ready);
endinterface

[rtl/mqrf_ctrl.sv]
// ----------------------------------------------------------------------------
// mqrf_ctrl
// Request sequencer: takes a request, lets the datapath execute it for one
// cycle and then holds the response until it is taken.
// ----------------------------------------------------------------------------
module mqrf_ctrl import mqrf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output mqrf_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = (state_ff == ST_RESP);
   assign cmd.capture = req_valid && (state_ff == ST_IDLE);
   assign cmd.execute = (state_ff == ST_EXEC);

endmodule

[rtl/mqrf_datapath.sv]
// ----------------------------------------------------------------------------
// mqrf_datapath
// Per-queue pointers, fill counts and lost-word counters, the shared word
// store and the response registers.
// ----------------------------------------------------------------------------
module mqrf_datapath import mqrf_pkg::*; #(
   parameter int QUEUE_COUNT = DEF_QUEUE_COUNT,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  mqrf_cmd_type        cmd,
   input  mode_type            req_mode,
   input  logic [QIDX_W-1:0]   req_queue_index,
   input  logic [WORD_W-1:0]   req_write_word,
   output status_type          rsp_status,
   output logic [WORD_W-1:0]   rsp_read_word,
   output logic [FILL_W-1:0]   rsp_fill_level,
   output logic [WORD_W-1:0]   rsp_lost_total
);

   localparam int QW   = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam int PW   = $clog2(QUEUE_DEPTH);
   localparam int CW   = $clog2(QUEUE_DEPTH + 1);
   localparam int SIZE = QUEUE_COUNT * QUEUE_DEPTH;
   localparam int AW   = $clog2(SIZE);

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   mode_type            mode_ff;
   logic [QIDX_W-1:0]   qidx_ff;
   logic [WORD_W-1:0]   word_ff;

   logic [PW-1:0]       rp_ff   [QUEUE_COUNT];
   logic [PW-1:0]       rp_in   [QUEUE_COUNT];
   logic [PW-1:0]       wp_ff   [QUEUE_COUNT];
   logic [PW-1:0]       wp_in   [QUEUE_COUNT];
   logic [CW-1:0]       cnt_ff  [QUEUE_COUNT];
   logic [CW-1:0]       cnt_in  [QUEUE_COUNT];
   logic [WORD_W-1:0]   lost_ff [QUEUE_COUNT];
   logic [WORD_W-1:0]   lost_in [QUEUE_COUNT];

   status_type          status_ff;
   status_type          status_in;
   logic [FILL_W-1:0]   fill_ff;
   logic [FILL_W-1:0]   fill_in;
   logic [WORD_W-1:0]   total_ff;
   logic [WORD_W-1:0]   total_in;
   logic                sel_ff;
   logic                sel_in;

   logic [WORD_W-1:0]   store [SIZE];
   logic [WORD_W-1:0]   rd_data_ff;
   logic                mem_we;
   logic                mem_re;
   logic [AW-1:0]       mem_addr;
   logic [AW-1:0]       base;
   logic [QW-1:0]       q;
   logic                bad;

   assign q    = QW'(qidx_ff);
   assign bad  = int'(qidx_ff) >= QUEUE_COUNT;
   assign base = AW'(q) * AW'(QUEUE_DEPTH);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         qidx_ff <= req_queue_index;
         word_ff <= req_write_word;
      end
   end

   always_comb begin
      rp_in     = rp_ff;
      wp_in     = wp_ff;
      cnt_in    = cnt_ff;
      lost_in   = lost_ff;
      status_in = status_ff;
      fill_in   = fill_ff;
      total_in  = total_ff;
      sel_in    = sel_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = '0;
      if (cmd.execute) begin
         sel_in    = 1'b0;
         status_in = STATUS_OK;
         if (bad) begin
            status_in = STATUS_BAD;
            fill_in   = '0;
            total_in  = '0;
         end else begin
            case (mode_ff)
               MODE_CLEAR: begin
                  rp_in[q]   = '0;
                  wp_in[q]   = '0;
                  cnt_in[q]  = '0;
                  lost_in[q] = '0;
               end
               MODE_WRITE: begin
                  if (cnt_ff[q] == CW'(QUEUE_DEPTH)) begin
                     lost_in[q] = lost_ff[q] + 1'b1;
                     status_in  = STATUS_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_addr  = base + AW'(wp_ff[q]);
                     wp_in[q]  = next_ptr(wp_ff[q]);
                     cnt_in[q] = cnt_ff[q] + 1'b1;
                  end
               end
               MODE_READ: begin
                  if (cnt_ff[q] == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     mem_re    = 1'b1;
                     mem_addr  = base + AW'(rp_ff[q]);
                     rp_in[q]  = next_ptr(rp_ff[q]);
                     cnt_in[q] = cnt_ff[q] - 1'b1;
                     sel_in    = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            fill_in  = FILL_W'(cnt_in[q]);
            total_in = lost_in[q];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff   <= '{default: '0};
         wp_ff   <= '{default: '0};
         cnt_ff  <= '{default: '0};
         lost_ff <= '{default: '0};
      end else begin
         rp_ff   <= rp_in;
         wp_ff   <= wp_in;
         cnt_ff  <= cnt_in;
         lost_ff <= lost_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      fill_ff   <= fill_in;
      total_ff  <= total_in;
      sel_ff    <= sel_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_addr] <= word_ff;
      end
      if (mem_re) begin
         rd_data_ff <= store[mem_addr];
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_read_word  = sel_ff ? rd_data_ff : '0;
   assign rsp_fill_level = fill_ff;
   assign rsp_lost_total = total_ff;

endmodule

[rtl/multi_queue_ring_fifo_core.sv]
// ----------------------------------------------------------------------------
// multi_queue_ring_fifo_core
// Several circular word queues sharing one storage array. Each request
// clears, appends to or reads one queue and returns one response.
// ----------------------------------------------------------------------------
//   Channel    Direction   Carries
//   req_chan   in          mode, queue_index, write_word
//   rsp_chan   out         status, read_word, fill_level, lost_total
//
// A request is taken, then executes with at most one access to the
// single-port word store, and then its response is presented.
// The next request can be taken, at the earliest, in the cycle after the response is taken.
// A stalled response holds its fields until rsp_chan.ready is high.
// Reset clears all pointers, fill counts and lost-word counters at once.
// The word store is not cleared.
// ----------------------------------------------------------------------------
module multi_queue_ring_fifo_core import mqrf_pkg::*; #(
   parameter int QUEUE_COUNT = DEF_QUEUE_COUNT,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   mqrf_req_if.sink    req_chan,
   mqrf_rsp_if.source  rsp_chan
);

   mqrf_cmd_type cmd;

   mqrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   mqrf_datapath #(
      .QUEUE_COUNT (QUEUE_COUNT),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_mode        (req_chan.mode),
      .req_queue_index (req_chan.queue_index),
      .req_write_word  (req_chan.write_word),
      .rsp_status      (rsp_chan.status),
      .rsp_read_word   (rsp_chan.read_word),
      .rsp_fill_level  (rsp_chan.fill_level),
      .rsp_lost_total  (rsp_chan.lost_total)
   );

endmodule

[dv/mqrf_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mqrf_checker
// Watches the request and response channels of the multi-queue FIFO, keeps
// its own image of every queue, predicts each response from the accepted
// requests and compares the responses field by field in order.
// ----------------------------------------------------------------------------
module mqrf_checker import mqrf_pkg::*; #(
   parameter int QUEUE_COUNT = DEF_QUEUE_COUNT,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   mqrf_req_if  req_chan,
   mqrf_rsp_if  rsp_chan,
   output int   failure_count,
   output int   pending_count,
   output int   response_count,
   output int   full_count,
   output int   empty_count
);

   typedef struct packed {
      status_type        status;
      logic [WORD_W-1:0] read_word;
      logic [FILL_W-1:0] fill_level;
      logic [WORD_W-1:0] lost_total;
   } response_type;

   logic [WORD_W-1:0] word_image [QUEUE_COUNT*QUEUE_DEPTH];
   int unsigned       read_offset [QUEUE_COUNT];
   int unsigned       write_offset [QUEUE_COUNT];
   int unsigned       words_held [QUEUE_COUNT];
   logic [WORD_W-1:0] lost_words [QUEUE_COUNT];
   response_type      awaited_responses [$];
   int                failures = 0;
   int                responses = 0;
   int                fulls = 0;
   int                empties = 0;

   initial begin
      foreach (word_image[i]) word_image[i] = '0;
      for (int q = 0; q < QUEUE_COUNT; q++) begin
         read_offset[q] = 0;
         write_offset[q] = 0;
         words_held[q] = 0;
         lost_words[q] = '0;
      end
   end

   function automatic int unsigned next_offset(int unsigned offset);
      return (offset + 1 >= QUEUE_DEPTH) ? 0 : offset + 1;
   endfunction

   function automatic response_type predict_response(mode_type mode,
                                                     logic [QIDX_W-1:0] queue_sel,
                                                     logic [WORD_W-1:0] word);
      response_type result;
      int unsigned  slot;
      result = '0;
      if (queue_sel >= QUEUE_COUNT) begin
         result.status = STATUS_BAD;
         return result;
      end
      case (mode)
         MODE_CLEAR: begin
            read_offset[queue_sel] = 0;
            write_offset[queue_sel] = 0;
            words_held[queue_sel] = 0;
            lost_words[queue_sel] = '0;
         end
         MODE_WRITE: begin
            if (words_held[queue_sel] >= QUEUE_DEPTH) begin
               lost_words[queue_sel] = lost_words[queue_sel] + 1'b1;
               result.status = STATUS_FULL;
            end else begin
               slot = queue_sel * QUEUE_DEPTH + write_offset[queue_sel];
               word_image[slot] = word;
               write_offset[queue_sel] = next_offset(write_offset[queue_sel]);
               words_held[queue_sel] = words_held[queue_sel] + 1;
            end
         end
         MODE_READ: begin
            if (words_held[queue_sel] == 0) begin
               result.status = STATUS_EMPTY;
            end else begin
               slot = queue_sel * QUEUE_DEPTH + read_offset[queue_sel];
               result.read_word = word_image[slot];
               read_offset[queue_sel] = next_offset(read_offset[queue_sel]);
               words_held[queue_sel] = words_held[queue_sel] - 1;
            end
         end
         default: begin
         end
      endcase
      result.fill_level = FILL_W'(words_held[queue_sel]);
      result.lost_total = lost_words[queue_sel];
      return result;
   endfunction

   task automatic compare_field(string field, logic [WORD_W-1:0] wanted,
                                logic [WORD_W-1:0] seen);
      if (wanted !== seen) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, wanted, seen);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch
      response_type observed;
      response_type wanted;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            observed.status = rsp_chan.status;
            observed.read_word = rsp_chan.read_word;
            observed.fill_level = rsp_chan.fill_level;
            observed.lost_total = rsp_chan.lost_total;
            responses++;
            if (awaited_responses.size() == 0) begin
               $display("%0t: response with no request outstanding, expected none, actual %h",
                        $time, observed);
               failures++;
            end else begin
               wanted = awaited_responses.pop_front();
               compare_field("status", WORD_W'(wanted.status), WORD_W'(observed.status));
               compare_field("read_word", wanted.read_word, observed.read_word);
               compare_field("fill_level", WORD_W'(wanted.fill_level),
                             WORD_W'(observed.fill_level));
               compare_field("lost_total", wanted.lost_total, observed.lost_total);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            wanted = predict_response(req_chan.mode, req_chan.queue_index,
                                      req_chan.write_word);
            if (wanted.status == STATUS_FULL) fulls++;
            if (wanted.status == STATUS_EMPTY) empties++;
            awaited_responses.push_back(wanted);
         end
      end
      failure_count <= failures;
      pending_count <= awaited_responses.size();
      response_count <= responses;
      full_count <= fulls;
      empty_count <= empties;
   end

endmodule

[dv/multi_queue_ring_fifo_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_queue_ring_fifo_core_test
// Drives clear, write, read and unused-mode requests into the multi-queue
// FIFO: a short directed set, then random runs biased to fill or drain one
// queue at a time, with random gaps on both channels, one long response
// stall and two full drains. A checker beside the DUT predicts and compares.
// ----------------------------------------------------------------------------
module multi_queue_ring_fifo_core_test;
   import mqrf_pkg::*;

   localparam int       QUEUE_COUNT = DEF_QUEUE_COUNT;
   localparam int       QUEUE_DEPTH = DEF_QUEUE_DEPTH;
   localparam mode_type MODE_UNUSED = 2'd3;
   localparam int       RANDOM_REQUESTS = 1880;
   localparam int       QUIET_TAIL = 150;
   localparam int       HOLD_AT = 600;
   localparam int       DRAIN_AT = 1100;
   localparam int       LONG_HOLD = 80;
   localparam int       TIMEOUT_NS = 1_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mqrf_req_if req_chan ();
   mqrf_rsp_if rsp_chan ();

   int failure_count;
   int pending_count;
   int response_count;
   int full_count;
   int empty_count;

   int send_idle_pct = 20;
   int take_idle_pct = 20;
   int hold_requests = 0;
   int holds_taken = 0;
   int mode_tally [4] = '{0, 0, 0, 0};
   int bad_index_tally = 0;

   multi_queue_ring_fifo_core #(
      .QUEUE_COUNT (QUEUE_COUNT),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mqrf_checker #(
      .QUEUE_COUNT (QUEUE_COUNT),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) response_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .failure_count  (failure_count),
      .pending_count  (pending_count),
      .response_count (response_count),
      .full_count     (full_count),
      .empty_count    (empty_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   // The response side stalls in random bursts, and once for a long stretch
   // when the request side asks for it.
   initial begin
      rsp_chan.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (holds_taken != hold_requests) begin
            holds_taken++;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else if (take_idle_pct > 0 && $urandom_range(99) < take_idle_pct) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_request(mode_type mode, logic [QIDX_W-1:0] queue_sel,
                               logic [WORD_W-1:0] word);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode <= mode;
      req_chan.queue_index <= queue_sel;
      req_chan.write_word <= word;
      do @(posedge clock); while (!req_chan.ready);
      mode_tally[mode]++;
      if (queue_sel >= QUEUE_COUNT) bad_index_tally++;
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic random_request(int focus, int write_pct);
      int                pick;
      mode_type          mode;
      logic [QIDX_W-1:0] queue_sel;
      logic [WORD_W-1:0] word;
      pick = $urandom_range(99);
      queue_sel = ($urandom_range(3) == 0) ? QIDX_W'($urandom_range(QUEUE_COUNT - 1))
                                           : QIDX_W'(focus);
      word = $urandom;
      case ($urandom_range(15))
         0: word = '0;
         1: word = '1;
         default: begin
         end
      endcase
      if (pick < 3) begin
         queue_sel = QIDX_W'($urandom_range(7, QUEUE_COUNT));
         mode = mode_type'($urandom_range(3));
      end else if (pick < 5) begin
         mode = MODE_UNUSED;
      end else if (pick < 8) begin
         mode = MODE_CLEAR;
      end else begin
         mode = ($urandom_range(99) < write_pct) ? MODE_WRITE : MODE_READ;
      end
      send_request(mode, queue_sel, word);
   endtask

   initial begin
      int run_left;
      int focus;
      int write_pct;
      run_left = 0;
      focus = 0;
      write_pct = 50;
      req_chan.valid <= 1'b0;
      req_chan.mode <= MODE_CLEAR;
      req_chan.queue_index <= '0;
      req_chan.write_word <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(MODE_READ, 0, 32'h1234_5678);
      send_request(MODE_WRITE, 0, 32'h0000_0000);
      send_request(MODE_WRITE, 0, 32'hFFFF_FFFF);
      send_request(MODE_WRITE, 1, 32'h8000_0001);
      send_request(MODE_WRITE, 3, 32'h7FFF_FFFE);
      send_request(MODE_UNUSED, 0, 32'hFFFF_FFFF);
      send_request(MODE_READ, 0, 32'h0000_0000);
      send_request(MODE_READ, 0, 32'hFFFF_FFFF);
      send_request(MODE_READ, 0, 32'h0000_0000);
      send_request(MODE_CLEAR, 4, 32'hFFFF_FFFF);
      send_request(MODE_WRITE, 5, 32'hFFFF_FFFF);
      send_request(MODE_READ, 6, 32'h0000_0000);
      send_request(MODE_UNUSED, 7, 32'hFFFF_FFFF);
      send_request(MODE_CLEAR, 1, 32'h0000_0000);
      send_request(MODE_READ, 1, 32'h0000_0000);
      send_request(MODE_WRITE, 2, 32'h5555_AAAA);
      send_request(MODE_READ, 3, 32'h0000_0000);
      send_request(MODE_READ, 2, 32'h0000_0000);
      send_request(MODE_CLEAR, 3, 32'hAAAA_5555);
      send_request(MODE_UNUSED, 3, 32'h0000_0000);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(10, 80);
            focus = $urandom_range(QUEUE_COUNT - 1);
            case ($urandom_range(2))
               0: write_pct = 85;
               1: write_pct = 15;
               default: write_pct = 50;
            endcase
            if (n < RANDOM_REQUESTS - QUIET_TAIL) begin
               send_idle_pct = 15 * $urandom_range(2);
               take_idle_pct = 15 * $urandom_range(2);
            end
         end
         if (n == HOLD_AT) begin
            hold_requests <= hold_requests + 1;
            send_idle_pct = 0;
         end
         if (n == DRAIN_AT) wait_for_drain();
         if (n == RANDOM_REQUESTS - QUIET_TAIL) begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end
         random_request(focus, write_pct);
         run_left--;
      end

      wait_for_drain();
      repeat (8) @(posedge clock);
      $display("Sent %0d clears, %0d writes, %0d reads and %0d unused-kind requests,",
               mode_tally[MODE_CLEAR], mode_tally[MODE_WRITE], mode_tally[MODE_READ],
               mode_tally[MODE_UNUSED]);
      $display("%0d to a missing queue; checked %0d responses, %0d full and %0d empty.",
               bad_index_tally, response_count, full_count, empty_count);
      if (failure_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/mqrf_pkg.sv
rtl/mqrf_chan_if.sv
rtl/mqrf_ctrl.sv
rtl/mqrf_datapath.sv
rtl/multi_queue_ring_fifo_core.sv
dv/mqrf_checker.sv
dv/multi_queue_ring_fifo_core_test.sv
